// ===== sv/tchpe_pkg.sv =====
// ----------------------------------------------------------------------------
// tchpe_pkg
// Shared types, codes and constants of the two-class HMM parameter estimator.
// ----------------------------------------------------------------------------
package tchpe_pkg;

  localparam int NUM_FEAT   = 4;
  localparam int NUM_PAIR   = 10;
  localparam int NUM_CLASS  = 2;
  localparam int STAT_W     = 41;
  localparam int RATIO_W    = 17;
  localparam int RATIO_SHIFT = 16;
  localparam int FIELD_W    = 16;
  localparam int ITEM_W     = 6;

  typedef enum logic [1:0] {
    CMD_ACCUM  = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_PRIOR = 3'd0,
    KIND_TRANS = 3'd1,
    KIND_MEAN  = 3'd2,
    KIND_COV   = 3'd3,
    KIND_TOTAL = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_ACC_ADD,
    ST_REP_ITEM,
    ST_COV_B,
    ST_COV_Q,
    ST_DIV_PREP,
    ST_DIV_RUN,
    ST_DIV_DONE,
    ST_EMIT
  } state_t;

  // first item of each group in the report run, and the last item
  localparam logic [ITEM_W-1:0] ITEM_PRIOR = 6'd0;
  localparam logic [ITEM_W-1:0] ITEM_TRANS = 6'd2;
  localparam logic [ITEM_W-1:0] ITEM_MEAN  = 6'd6;
  localparam logic [ITEM_W-1:0] ITEM_COV   = 6'd14;
  localparam logic [ITEM_W-1:0] ITEM_TOTAL = 6'd46;
  localparam logic [ITEM_W-1:0] ITEM_LAST  = 6'd47;

  // upper-triangle slot of feature pair (j,k)
  function automatic logic [3:0] pair_index(input logic [1:0] j, input logic [1:0] k);
    logic [3:0] p;
    case ({j, k})
      4'b0000: p = 4'd0;
      4'b0001, 4'b0100: p = 4'd1;
      4'b0010, 4'b1000: p = 4'd2;
      4'b0011, 4'b1100: p = 4'd3;
      4'b0101: p = 4'd4;
      4'b0110, 4'b1001: p = 4'd5;
      4'b0111, 4'b1101: p = 4'd6;
      4'b1010: p = 4'd7;
      4'b1011, 4'b1110: p = 4'd8;
      default: p = 4'd9;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/tchpe_if.sv =====
// ----------------------------------------------------------------------------
// tchpe channel interfaces
// Valid/ready channels for input samples and report items.
// ----------------------------------------------------------------------------
interface tchpe_in_if;
  import tchpe_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic                      seq_start;
  logic                      label;
  logic signed [FIELD_W-1:0] feature_a;
  logic signed [FIELD_W-1:0] feature_b;
  logic signed [FIELD_W-1:0] feature_c;
  logic signed [FIELD_W-1:0] feature_d;

  modport source (output valid, cmd, seq_start, label, feature_a, feature_b,
                  feature_c, feature_d, input ready);
  modport sink (input valid, cmd, seq_start, label, feature_a, feature_b,
                feature_c, feature_d, output ready);
endinterface

interface tchpe_out_if;
  import tchpe_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [2:0]               item_kind;
  logic                     class_index;
  logic [1:0]               row_index;
  logic [1:0]               col_index;
  logic signed [STAT_W-1:0] stat_value;
  logic [RATIO_W-1:0]       ratio;
  logic                     valid_res;
  logic                     last;

  modport source (output valid, item_kind, class_index, row_index, col_index,
                  stat_value, ratio, valid_res, last, input ready);
  modport sink (input valid, item_kind, class_index, row_index, col_index,
                stat_value, ratio, valid_res, last, output ready);
endinterface

// ===== sv/two_class_hmm_parameter_estimator.sv =====
// ----------------------------------------------------------------------------
// two_class_hmm_parameter_estimator
// Accumulates labelled samples and reads out HMM priors, transitions,
// per-class means and covariances.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : commands. cmd 0 adds a sample (class, seq_start, four Q8.8
//            features), cmd 1 starts a report run, cmd 2 clears all stats.
//            cmd 3 is dropped.
//   out_ch : report items, 48 per run, last set on the final one.
// Timing:
//   A sample first updates counts and sums, then runs each of the ten
//   cross products through the shared multiplier.
//   In a report each division runs one quotient bit per cycle through the
//   shared divider (DW = 68 by default); a covariance needs a two-step
//   multiply and two divisions.
//   in_ch.ready is high only while the sequencer is idle.
// Reset / stall:
//   rst_n (sync, active low) clears all statistics at once; no sweep.
//   A single output register holds each item; while the receiver stalls
//   the report run waits in place, nothing is lost or repeated.
// ----------------------------------------------------------------------------
module two_class_hmm_parameter_estimator #(
  parameter int MAX_SAMPLES  = 65536,
  parameter int FEATURE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  tchpe_in_if.sink    in_ch,
  tchpe_out_if.source out_ch
);
  import tchpe_pkg::*;

  // counter, sum and datapath widths
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int DEN_W  = CNT_W + 1;
  localparam int FSW    = FEATURE_BITS + CNT_W;        // feature sum
  localparam int XSW    = 2 * FEATURE_BITS + CNT_W;    // cross sum
  localparam int HW     = (FSW + 1) / 2;               // multiplier low chunk
  localparam int MR_W   = FSW + HW;
  localparam int PRD_W  = 2 * FSW;
  localparam int PW     = PRD_W + 1;                   // signed product
  localparam int DW0    = PRD_W + 2;
  localparam int DW     = (DW0 > STAT_W + 1) ? DW0 : STAT_W + 1;
  localparam int DCW    = $clog2(DW + 1);
  localparam int RAW_W  = (FEATURE_BITS > FIELD_W) ? FEATURE_BITS : FIELD_W;
  localparam int NFS    = NUM_CLASS * NUM_FEAT;
  localparam int NXS    = NUM_CLASS * NUM_PAIR;
  localparam int XA_W   = $clog2(NXS);
  // covariance terms wrap at 64 bits
  localparam int WRAP_W  = (PW < 64) ? PW : 64;
  localparam int DWRAP_W = (DW < 64) ? DW : 64;

  function automatic logic [FSW-1:0] take_feature(input logic [FIELD_W-1:0] raw);
    logic [RAW_W-1:0]        ext;
    logic [FEATURE_BITS-1:0] v;
    ext = RAW_W'(raw);
    v   = ext[FEATURE_BITS-1:0];
    return FSW'(signed'(v));
  endfunction

  function automatic logic [FSW-1:0] mag_fs(input logic [FSW-1:0] v);
    return v[FSW-1] ? (~v + 1'b1) : v;
  endfunction

  // ---------------- registers ----------------
  state_t state_r, state_nxt;

  // statistics
  logic [CNT_W-1:0] prior_cnt_r [NUM_CLASS];
  logic [CNT_W-1:0] prior_cnt_nxt [NUM_CLASS];
  logic [CNT_W-1:0] trans_cnt_r [4];
  logic [CNT_W-1:0] trans_cnt_nxt [4];
  logic [CNT_W-1:0] class_cnt_r [NUM_CLASS];
  logic [CNT_W-1:0] class_cnt_nxt [NUM_CLASS];
  logic [CNT_W-1:0] seq_total_r, seq_total_nxt;
  logic [CNT_W-1:0] sample_total_r, sample_total_nxt;
  logic             prev_label_r, prev_label_nxt;
  logic             have_prev_r, have_prev_nxt;
  logic [FSW-1:0]   fsum_r [NFS];
  logic [FSW-1:0]   fsum_nxt [NFS];
  logic [XSW-1:0]   xsum_r [NXS];
  logic [XSW-1:0]   xsum_nxt [NXS];

  // sample being accumulated
  logic [FSW-1:0] f_r [NUM_FEAT];
  logic [FSW-1:0] f_nxt [NUM_FEAT];
  logic           acc_c_r, acc_c_nxt;
  logic [1:0]     acc_j_r, acc_j_nxt, acc_k_r, acc_k_nxt;
  logic [3:0]     acc_p_r, acc_p_nxt;
  logic           mode_rep_r, mode_rep_nxt;

  // shared multiplier
  logic [FSW-1:0]   mul_a_r, mul_a_nxt, mul_b_r, mul_b_nxt;
  logic             mul_neg_r, mul_neg_nxt;
  logic [MR_W-1:0]  mreg_r, mreg_nxt;
  logic [PRD_W-1:0] prod_r, prod_nxt;

  // shared divider
  logic [DW-1:0]    div_quo_r, div_quo_nxt;
  logic [DEN_W-1:0] div_rem_r, div_rem_nxt;
  logic [DEN_W-1:0] div_den_r, div_den_nxt;
  logic             div_neg_r, div_neg_nxt;
  logic [DCW-1:0]   div_cnt_r, div_cnt_nxt;
  logic             div_phase_r, div_phase_nxt;

  // report item under work
  logic [ITEM_W-1:0]  item_r, item_nxt;
  kind_t              rep_kind_r, rep_kind_nxt;
  logic               rep_c_r, rep_c_nxt;
  logic [1:0]         rep_j_r, rep_j_nxt, rep_k_r, rep_k_nxt;
  logic [CNT_W-1:0]   rep_cnt_r, rep_cnt_nxt;
  logic [STAT_W-1:0]  rep_stat_r, rep_stat_nxt;
  logic [RATIO_W-1:0] rep_ratio_r, rep_ratio_nxt;
  logic               rep_valid_r, rep_valid_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  kind_t              out_kind_r, out_kind_nxt;
  logic               out_c_r, out_c_nxt;
  logic [1:0]         out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  logic [STAT_W-1:0]  out_stat_r, out_stat_nxt;
  logic [RATIO_W-1:0] out_ratio_r, out_ratio_nxt;
  logic               out_vres_r, out_vres_nxt;
  logic               out_last_r, out_last_nxt;

  // ---------------- combinational helpers ----------------
  logic [FSW-1:0]   feat_in [NUM_FEAT];
  logic [MR_W-1:0]  mul_out;
  logic [PW-1:0]    spr;
  logic [DEN_W:0]   div_t;
  logic [DEN_W:0]   div_sub;
  logic             div_ge;
  logic [DW-1:0]    div_res;
  logic [DW-1:0]    div_mag;
  kind_t            dec_kind;
  logic             dec_c;
  logic [1:0]       dec_j, dec_k;
  logic [2:0]       fs_addr;
  logic [FSW-1:0]   fs_rd;
  logic [XA_W-1:0]  xs_addr;
  logic [XSW-1:0]   xs_rd;

  assign feat_in[0] = take_feature(in_ch.feature_a);
  assign feat_in[1] = take_feature(in_ch.feature_b);
  assign feat_in[2] = take_feature(in_ch.feature_c);
  assign feat_in[3] = take_feature(in_ch.feature_d);

  // one multiplier, low chunk of B in MUL0, high chunk in MUL1
  assign mul_out = (state_r == ST_MUL0) ?
                   MR_W'(MR_W'(mul_a_r) * MR_W'(mul_b_r[HW-1:0])) :
                   MR_W'(MR_W'(mul_a_r) * MR_W'(mul_b_r[FSW-1:HW]));
  assign spr     = mul_neg_r ? PW'(-{1'b0, prod_r}) : {1'b0, prod_r};

  // restoring divider step
  assign div_t   = {div_rem_r, div_quo_r[DW-1]};
  assign div_ge  = div_t >= {1'b0, div_den_r};
  assign div_sub = div_t - {1'b0, div_den_r};
  assign div_res = div_neg_r ? (~div_quo_r + 1'b1) : div_quo_r;
  assign div_mag = div_quo_r[DW-1] ? (~div_quo_r + 1'b1) : div_quo_r;

  // report item decode
  always_comb begin
    logic [ITEM_W-1:0] off;
    off      = '0;
    dec_kind = KIND_TOTAL;
    dec_c    = 1'b0;
    dec_j    = 2'd0;
    dec_k    = 2'd0;
    case (item_r) inside
      [ITEM_PRIOR:ITEM_TRANS-6'd1]: begin
        dec_kind = KIND_PRIOR;
        dec_c    = item_r[0];
      end
      [ITEM_TRANS:ITEM_MEAN-6'd1]: begin
        off      = item_r - ITEM_TRANS;
        dec_kind = KIND_TRANS;
        dec_c    = off[1];
        dec_j    = {1'b0, off[0]};
      end
      [ITEM_MEAN:ITEM_COV-6'd1]: begin
        off      = item_r - ITEM_MEAN;
        dec_kind = KIND_MEAN;
        dec_c    = off[2];
        dec_j    = off[1:0];
      end
      [ITEM_COV:ITEM_TOTAL-6'd1]: begin
        off      = item_r - ITEM_COV;
        dec_kind = KIND_COV;
        dec_c    = off[4];
        dec_j    = off[3:2];
        dec_k    = off[1:0];
      end
      default: begin
        dec_kind = KIND_TOTAL;
        dec_j    = {1'b0, item_r == ITEM_LAST};
      end
    endcase
  end

  // single read port on each sum array
  assign fs_addr = (state_r == ST_COV_B) ? {rep_c_r, rep_k_r} : {dec_c, dec_j};
  assign fs_rd   = fsum_r[fs_addr];
  assign xs_addr = rep_c_r ? XA_W'(pair_index(rep_j_r, rep_k_r)) + XA_W'(NUM_PAIR)
                           : XA_W'(pair_index(rep_j_r, rep_k_r));
  assign xs_rd   = xsum_r[xs_addr];

  assign in_ch.ready = (state_r == ST_IDLE);

  // ---------------- sequencer ----------------
  always_comb begin
    logic [1:0]      nj, nk;
    logic [XA_W-1:0] acc_idx;
    logic [DEN_W-1:0] tsum;
    logic [DW-1:0]   dsum;
    nj      = acc_j_r;
    nk      = acc_k_r;
    acc_idx = acc_c_r ? XA_W'(acc_p_r) + XA_W'(NUM_PAIR) : XA_W'(acc_p_r);
    tsum    = '0;
    dsum    = '0;

    state_nxt        = state_r;
    prior_cnt_nxt    = prior_cnt_r;
    trans_cnt_nxt    = trans_cnt_r;
    class_cnt_nxt    = class_cnt_r;
    seq_total_nxt    = seq_total_r;
    sample_total_nxt = sample_total_r;
    prev_label_nxt   = prev_label_r;
    have_prev_nxt    = have_prev_r;
    fsum_nxt         = fsum_r;
    xsum_nxt         = xsum_r;
    f_nxt            = f_r;
    acc_c_nxt        = acc_c_r;
    acc_j_nxt        = acc_j_r;
    acc_k_nxt        = acc_k_r;
    acc_p_nxt        = acc_p_r;
    mode_rep_nxt     = mode_rep_r;
    mul_a_nxt        = mul_a_r;
    mul_b_nxt        = mul_b_r;
    mul_neg_nxt      = mul_neg_r;
    mreg_nxt         = mreg_r;
    prod_nxt         = prod_r;
    div_quo_nxt      = div_quo_r;
    div_rem_nxt      = div_rem_r;
    div_den_nxt      = div_den_r;
    div_neg_nxt      = div_neg_r;
    div_cnt_nxt      = div_cnt_r;
    div_phase_nxt    = div_phase_r;
    item_nxt         = item_r;
    rep_kind_nxt     = rep_kind_r;
    rep_c_nxt        = rep_c_r;
    rep_j_nxt        = rep_j_r;
    rep_k_nxt        = rep_k_r;
    rep_cnt_nxt      = rep_cnt_r;
    rep_stat_nxt     = rep_stat_r;
    rep_ratio_nxt    = rep_ratio_r;
    rep_valid_nxt    = rep_valid_r;
    out_valid_nxt    = out_valid_r & ~out_ch.ready;
    out_kind_nxt     = out_kind_r;
    out_c_nxt        = out_c_r;
    out_row_nxt      = out_row_r;
    out_col_nxt      = out_col_r;
    out_stat_nxt     = out_stat_r;
    out_ratio_nxt    = out_ratio_r;
    out_vres_nxt     = out_vres_r;
    out_last_nxt     = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.cmd)
            CMD_ACCUM: begin
              // full store: sample dropped
              if (sample_total_r < CNT_W'(MAX_SAMPLES)) begin
                if (in_ch.seq_start || !have_prev_r) begin
                  seq_total_nxt = CNT_W'(seq_total_r + 1'b1);
                  prior_cnt_nxt[in_ch.label] = CNT_W'(prior_cnt_r[in_ch.label] + 1'b1);
                end else begin
                  trans_cnt_nxt[{prev_label_r, in_ch.label}] =
                    CNT_W'(trans_cnt_r[{prev_label_r, in_ch.label}] + 1'b1);
                end
                prev_label_nxt   = in_ch.label;
                have_prev_nxt    = 1'b1;
                sample_total_nxt = CNT_W'(sample_total_r + 1'b1);
                class_cnt_nxt[in_ch.label] = CNT_W'(class_cnt_r[in_ch.label] + 1'b1);
                for (int e = 0; e < NFS; e++) begin
                  if ((e / NUM_FEAT) == int'(in_ch.label))
                    fsum_nxt[e] = fsum_r[e] + feat_in[e % NUM_FEAT];
                end
                f_nxt        = feat_in;
                acc_c_nxt    = in_ch.label;
                acc_j_nxt    = 2'd0;
                acc_k_nxt    = 2'd0;
                acc_p_nxt    = 4'd0;
                mode_rep_nxt = 1'b0;
                mul_a_nxt    = mag_fs(feat_in[0]);
                mul_b_nxt    = mag_fs(feat_in[0]);
                mul_neg_nxt  = 1'b0;
                state_nxt    = ST_MUL0;
              end
            end
            CMD_REPORT: begin
              item_nxt     = ITEM_PRIOR;
              mode_rep_nxt = 1'b1;
              state_nxt    = ST_REP_ITEM;
            end
            CMD_CLEAR: begin
              for (int i = 0; i < NUM_CLASS; i++) begin
                prior_cnt_nxt[i] = '0;
                class_cnt_nxt[i] = '0;
              end
              for (int i = 0; i < 4; i++) trans_cnt_nxt[i] = '0;
              for (int i = 0; i < NFS; i++) fsum_nxt[i] = '0;
              for (int i = 0; i < NXS; i++) xsum_nxt[i] = '0;
              seq_total_nxt    = '0;
              sample_total_nxt = '0;
              prev_label_nxt   = 1'b0;
              have_prev_nxt    = 1'b0;
            end
            default: ;
          endcase
        end
      end

      ST_MUL0: begin
        mreg_nxt  = mul_out;
        state_nxt = ST_MUL1;
      end

      ST_MUL1: begin
        prod_nxt  = PRD_W'(mreg_r);
        mreg_nxt  = mul_out;
        state_nxt = ST_MUL2;
      end

      ST_MUL2: begin
        prod_nxt  = prod_r + (PRD_W'(mreg_r) << HW);
        state_nxt = mode_rep_r ? ST_COV_Q : ST_ACC_ADD;
      end

      ST_ACC_ADD: begin
        for (int x = 0; x < NXS; x++) begin
          if (XA_W'(x) == acc_idx) xsum_nxt[x] = xsum_r[x] + XSW'(spr);
        end
        if (acc_k_r == 2'd3) begin
          nj = acc_j_r + 2'd1;
          nk = acc_j_r + 2'd1;
        end else begin
          nk = acc_k_r + 2'd1;
        end
        if (acc_j_r == 2'd3 && acc_k_r == 2'd3) begin
          state_nxt = ST_IDLE;
        end else begin
          acc_j_nxt   = nj;
          acc_k_nxt   = nk;
          acc_p_nxt   = acc_p_r + 4'd1;
          mul_a_nxt   = mag_fs(f_r[nj]);
          mul_b_nxt   = mag_fs(f_r[nk]);
          mul_neg_nxt = f_r[nj][FSW-1] ^ f_r[nk][FSW-1];
          state_nxt   = ST_MUL0;
        end
      end

      ST_REP_ITEM: begin
        rep_kind_nxt  = dec_kind;
        rep_c_nxt     = dec_c;
        rep_j_nxt     = dec_j;
        rep_k_nxt     = dec_k;
        rep_ratio_nxt = '0;
        rep_stat_nxt  = '0;
        rep_valid_nxt = 1'b0;
        div_phase_nxt = 1'b1;
        case (dec_kind)
          KIND_PRIOR: begin
            if (seq_total_r == '0) begin
              state_nxt = ST_EMIT;
            end else begin
              rep_stat_nxt = STAT_W'(prior_cnt_r[dec_c]);
              div_quo_nxt  = DW'(prior_cnt_r[dec_c]) << RATIO_SHIFT;
              div_den_nxt  = DEN_W'(seq_total_r);
              state_nxt    = ST_DIV_PREP;
            end
          end
          KIND_TRANS: begin
            tsum = DEN_W'(trans_cnt_r[{dec_c, 1'b0}]) + DEN_W'(trans_cnt_r[{dec_c, 1'b1}]);
            if (tsum == '0) begin
              state_nxt = ST_EMIT;
            end else begin
              rep_stat_nxt = STAT_W'(trans_cnt_r[{dec_c, dec_j[0]}]);
              div_quo_nxt  = DW'(trans_cnt_r[{dec_c, dec_j[0]}]) << RATIO_SHIFT;
              div_den_nxt  = tsum;
              state_nxt    = ST_DIV_PREP;
            end
          end
          KIND_MEAN: begin
            if (class_cnt_r[dec_c] == '0) begin
              state_nxt = ST_EMIT;
            end else begin
              div_quo_nxt = DW'(signed'(fs_rd));
              div_den_nxt = DEN_W'(class_cnt_r[dec_c]);
              state_nxt   = ST_DIV_PREP;
            end
          end
          KIND_COV: begin
            // needs n >= 2
            if (class_cnt_r[dec_c] < CNT_W'(2)) begin
              state_nxt = ST_EMIT;
            end else begin
              rep_cnt_nxt = class_cnt_r[dec_c];
              mul_a_nxt   = mag_fs(fs_rd);
              mul_neg_nxt = fs_rd[FSW-1];
              state_nxt   = ST_COV_B;
            end
          end
          default: begin
            rep_valid_nxt = 1'b1;
            rep_stat_nxt  = (item_r == ITEM_LAST) ? STAT_W'(seq_total_r)
                                                  : STAT_W'(sample_total_r);
            state_nxt     = ST_EMIT;
          end
        endcase
      end

      ST_COV_B: begin
        mul_b_nxt   = mag_fs(fs_rd);
        mul_neg_nxt = mul_neg_r ^ fs_rd[FSW-1];
        state_nxt   = ST_MUL0;
      end

      ST_COV_Q: begin
        // q = round(Sj*Sk / n), product taken modulo 2^64
        div_quo_nxt   = DW'(signed'(spr[WRAP_W-1:0]));
        div_den_nxt   = DEN_W'(rep_cnt_r);
        div_phase_nxt = 1'b0;
        state_nxt     = ST_DIV_PREP;
      end

      ST_DIV_PREP: begin
        // round half away: divide |num| + den/2
        div_neg_nxt = div_quo_r[DW-1];
        div_quo_nxt = div_mag + DW'(div_den_r >> 1);
        div_rem_nxt = '0;
        div_cnt_nxt = DCW'(DW);
        state_nxt   = ST_DIV_RUN;
      end

      ST_DIV_RUN: begin
        div_quo_nxt = {div_quo_r[DW-2:0], div_ge};
        div_rem_nxt = div_ge ? div_sub[DEN_W-1:0] : div_t[DEN_W-1:0];
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == DCW'(1)) state_nxt = ST_DIV_DONE;
      end

      ST_DIV_DONE: begin
        if (!div_phase_r) begin
          // (Sjk - q) / (n-1), difference taken modulo 2^64
          dsum          = DW'(signed'(xs_rd)) - div_res;
          div_quo_nxt   = DW'(signed'(dsum[DWRAP_W-1:0]));
          div_den_nxt   = DEN_W'(DEN_W'(rep_cnt_r) - 1'b1);
          div_phase_nxt = 1'b1;
          state_nxt     = ST_DIV_PREP;
        end else begin
          if (rep_kind_r == KIND_PRIOR || rep_kind_r == KIND_TRANS)
            rep_ratio_nxt = div_res[RATIO_W-1:0];
          else
            rep_stat_nxt = div_res[STAT_W-1:0];
          rep_valid_nxt = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = rep_kind_r;
          out_c_nxt     = rep_c_r;
          out_row_nxt   = rep_j_r;
          out_col_nxt   = rep_k_r;
          out_stat_nxt  = rep_stat_r;
          out_ratio_nxt = rep_ratio_r;
          out_vres_nxt  = rep_valid_r;
          out_last_nxt  = (item_r == ITEM_LAST);
          if (item_r == ITEM_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            item_nxt  = item_r + 1'b1;
            state_nxt = ST_REP_ITEM;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and statistics state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < NUM_CLASS; i++) begin
        prior_cnt_r[i] <= '0;
        class_cnt_r[i] <= '0;
      end
      for (int i = 0; i < 4; i++) trans_cnt_r[i] <= '0;
      for (int i = 0; i < NFS; i++) fsum_r[i] <= '0;
      for (int i = 0; i < NXS; i++) xsum_r[i] <= '0;
      seq_total_r    <= '0;
      sample_total_r <= '0;
      prev_label_r   <= 1'b0;
      have_prev_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      prior_cnt_r    <= prior_cnt_nxt;
      class_cnt_r    <= class_cnt_nxt;
      trans_cnt_r    <= trans_cnt_nxt;
      fsum_r         <= fsum_nxt;
      xsum_r         <= xsum_nxt;
      seq_total_r    <= seq_total_nxt;
      sample_total_r <= sample_total_nxt;
      prev_label_r   <= prev_label_nxt;
      have_prev_r    <= have_prev_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    f_r           <= f_nxt;
    acc_c_r       <= acc_c_nxt;
    acc_j_r       <= acc_j_nxt;
    acc_k_r       <= acc_k_nxt;
    acc_p_r       <= acc_p_nxt;
    mode_rep_r    <= mode_rep_nxt;
    mul_a_r       <= mul_a_nxt;
    mul_b_r       <= mul_b_nxt;
    mul_neg_r     <= mul_neg_nxt;
    mreg_r        <= mreg_nxt;
    prod_r        <= prod_nxt;
    div_quo_r     <= div_quo_nxt;
    div_rem_r     <= div_rem_nxt;
    div_den_r     <= div_den_nxt;
    div_neg_r     <= div_neg_nxt;
    div_cnt_r     <= div_cnt_nxt;
    div_phase_r   <= div_phase_nxt;
    item_r        <= item_nxt;
    rep_kind_r    <= rep_kind_nxt;
    rep_c_r       <= rep_c_nxt;
    rep_j_r       <= rep_j_nxt;
    rep_k_r       <= rep_k_nxt;
    rep_cnt_r     <= rep_cnt_nxt;
    rep_stat_r    <= rep_stat_nxt;
    rep_ratio_r   <= rep_ratio_nxt;
    rep_valid_r   <= rep_valid_nxt;
    out_kind_r    <= out_kind_nxt;
    out_c_r       <= out_c_nxt;
    out_row_r     <= out_row_nxt;
    out_col_r     <= out_col_nxt;
    out_stat_r    <= out_stat_nxt;
    out_ratio_r   <= out_ratio_nxt;
    out_vres_r    <= out_vres_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.item_kind   = out_kind_r;
  assign out_ch.class_index = out_c_r;
  assign out_ch.row_index   = out_row_r;
  assign out_ch.col_index   = out_col_r;
  assign out_ch.stat_value  = out_stat_r;
  assign out_ch.ratio       = out_ratio_r;
  assign out_ch.valid_res   = out_vres_r;
  assign out_ch.last        = out_last_r;

endmodule
